/* rtl/spcfa_pkg.sv */
// Shared types, constants and helper functions for the pair coin-flip assigner.
package spcfa_pkg;

  localparam int unsigned TwN = 312;
  localparam int unsigned TwM = 156;
  localparam int unsigned IdxW = 9;

  localparam logic [63:0] TwMatrix  = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TwUpper   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TwLower   = 64'h000000007FFFFFFF;
  localparam logic [63:0] TwInitMul = 64'd6364136223846793005;
  localparam logic [63:0] MixAdd    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2   = 64'h94d049bb133111eb;

  localparam logic KindColumn = 1'b0;
  localparam logic KindPair   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_SEED,
    ST_RF_RD0,
    ST_RF_RD1,
    ST_RF_RD2,
    ST_RF_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted word
    logic mix_start;   // v = base seed + column + const
    logic mix_step1;   // first multiply of the mixer
    logic mix_step2;   // second multiply of the mixer
    logic seed_step;   // write one seeding word
    logic rf_rd0;      // refill: read word k
    logic rf_rd1;      // refill: read word k+1
    logic rf_rd2;      // refill: read word k+M
    logic rf_wr;       // refill: write word k
    logic draw_rd;     // read word at position
    logic draw_out;    // temper and load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic seeded;
    logic seed_last;
    logic rf_last;
    logic pos_end;
    logic out_busy;
    logic mul_last;
  } dp_sts_t;

  function automatic logic [63:0] temper(input logic [63:0] x);
    logic [63:0] y;
    y = x ^ ((x >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

  function automatic logic [15:0] row_pos(input logic [16:0] row);
    logic [16:0] z;
    z = row - 17'd1;
    return z[15:0];
  endfunction

endpackage

/* rtl/spcfa_if.sv */
// Valid/ready channel interfaces for input, result and configuration words.
interface spcfa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] column_number;
  logic [16:0] first_row;
  logic [16:0] second_row;
  modport source (output valid, kind, column_number, first_row, second_row, input ready);
  modport sink (input valid, kind, column_number, first_row, second_row, output ready);
endinterface

interface spcfa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] column_out;
  logic [15:0] first_position;
  logic [15:0] second_position;
  logic        first_treated;
  modport source (output valid, column_out, first_position, second_position, first_treated,
                  input ready);
  modport sink (input valid, column_out, first_position, second_position, first_treated,
                output ready);
endinterface

interface spcfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/spcfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module spcfa_ram #(
  parameter int Width = 64,
  parameter int Depth = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/spcfa_datapath.sv */
// Datapath: seed mixer, twister state memory, refill and tempering, output register.
module spcfa_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  spcfa_pkg::dp_cmd_t  cmd,
  output spcfa_pkg::dp_sts_t  sts,
  spcfa_in_if.sink            in_ch,
  spcfa_out_if.source         out_ch,
  spcfa_cfg_if.sink           cfg_ch
);
  localparam int IW = spcfa_pkg::IdxW;

  logic [63:0] base_seed_r;
  logic        kind_r;
  logic [15:0] col_in_r, cur_col_r;
  logic [16:0] row1_r, row2_r;
  logic        seeded_r;
  logic [63:0] v_r;
  logic [IW-1:0] k_r, pos_r;
  logic [IW-1:0] kp1, km;
  logic [63:0] prev_r, wk_r, wk1_r;
  logic [63:0] ram_rd, ram_wd;
  logic [IW-1:0] ram_ra, ram_wa;
  logic        ram_we;
  logic [63:0] y, nv, seed_w, word;
  logic        out_valid_r;
  logic [15:0] o_col_r, o_p1_r, o_p2_r;
  logic        o_t_r;
  logic [1:0]  mul_ph_r;
  logic        mul_on, mul_last;
  logic [63:0] mul_x, mul_c, mul_p, mul_res, acc_r, mix_final;
  logic [31:0] mul_a, mul_b;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seed_r <= '0;
    end else if (cfg_ch.valid) begin
      base_seed_r <= cfg_ch.data;
    end
  end

  assign kp1 = (k_r == IW'(spcfa_pkg::TwN - 1)) ? '0 : k_r + 1'b1;
  assign km  = (k_r >= IW'(spcfa_pkg::TwN - spcfa_pkg::TwM))
             ? IW'(k_r - IW'(spcfa_pkg::TwN - spcfa_pkg::TwM))
             : IW'(k_r + IW'(spcfa_pkg::TwM));

  // The 64-bit products keep only their low half, built from three 32-bit partial
  // products one after another: low by low, low by high, then high by low.
  assign mul_on   = cmd.mix_step1 | cmd.mix_step2 | cmd.seed_step;
  assign mul_last = (mul_ph_r == 2'd2);

  always_comb begin
    mul_x = prev_r ^ (prev_r >> 62);
    mul_c = spcfa_pkg::TwInitMul;
    if (cmd.mix_step1) begin
      mul_x = v_r ^ (v_r >> 30);
      mul_c = spcfa_pkg::MixMul1;
    end else if (cmd.mix_step2) begin
      mul_x = v_r ^ (v_r >> 27);
      mul_c = spcfa_pkg::MixMul2;
    end
  end

  always_comb begin
    mul_a = mul_x[31:0];
    mul_b = mul_c[31:0];
    if (mul_ph_r == 2'd1) begin
      mul_b = mul_c[63:32];
    end else if (mul_ph_r == 2'd2) begin
      mul_a = mul_x[63:32];
    end
  end

  assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
  assign mul_res   = acc_r + {mul_p[31:0], 32'd0};
  assign mix_final = mul_res ^ (mul_res >> 31);

  assign y  = (wk_r & spcfa_pkg::TwUpper) | (wk1_r & spcfa_pkg::TwLower);
  assign nv = ram_rd ^ (y >> 1) ^ (y[0] ? spcfa_pkg::TwMatrix : 64'd0);
  assign seed_w = mul_res + 64'(k_r);
  assign word = spcfa_pkg::temper(ram_rd);

  always_comb begin
    ram_we = 1'b0;
    ram_wa = k_r;
    ram_wd = seed_w;
    ram_ra = pos_r;
    if (cmd.mix_step2) begin
      ram_we = mul_last;
      ram_wa = '0;
      ram_wd = mix_final;
    end else if (cmd.seed_step) begin
      ram_we = mul_last;
    end else if (cmd.rf_wr) begin
      ram_we = 1'b1;
      ram_wd = nv;
    end
    if (cmd.rf_rd0) begin
      ram_ra = k_r;
    end else if (cmd.rf_rd1) begin
      ram_ra = kp1;
    end else if (cmd.rf_rd2) begin
      ram_ra = km;
    end
  end

  spcfa_ram #(.Width(64), .Depth(spcfa_pkg::TwN)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd)
  );

  // Item capture, multiply accumulator, mixer, previous-word and refill operand registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r   <= in_ch.kind;
      col_in_r <= in_ch.column_number;
      row1_r   <= in_ch.first_row;
      row2_r   <= in_ch.second_row;
    end
    if (mul_on) begin
      acc_r <= (mul_ph_r == 2'd0) ? mul_p : mul_res;
    end
    if (cmd.mix_start) begin
      v_r <= base_seed_r + 64'(col_in_r) + spcfa_pkg::MixAdd;
    end else if (cmd.mix_step1 && mul_last) begin
      v_r <= mul_res;
    end
    // Seeding keeps the previous word in a register; the final mix lands here too.
    if (cmd.mix_step2 && mul_last) begin
      prev_r <= mix_final;
    end else if (cmd.seed_step && mul_last) begin
      prev_r <= seed_w;
    end
    if (cmd.rf_rd1) begin
      wk_r <= ram_rd;
    end
    if (cmd.rf_rd2) begin
      wk1_r <= ram_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r    <= 1'b0;
      cur_col_r   <= '0;
      k_r         <= '0;
      pos_r       <= IW'(spcfa_pkg::TwN);
      out_valid_r <= 1'b0;
      mul_ph_r    <= 2'd0;
    end else begin
      if (mul_on) begin
        mul_ph_r <= mul_last ? 2'd0 : mul_ph_r + 2'd1;
      end
      if (cmd.mix_start) begin
        cur_col_r <= col_in_r;
        k_r       <= IW'(1);
      end
      if (cmd.mix_step2 && mul_last) begin
        seeded_r <= 1'b1;
      end
      if (cmd.seed_step && mul_last) begin
        k_r <= kp1;
        if (k_r == IW'(spcfa_pkg::TwN - 1)) begin
          pos_r <= IW'(spcfa_pkg::TwN);
        end
      end
      if (cmd.rf_wr) begin
        k_r <= kp1;
        if (k_r == IW'(spcfa_pkg::TwN - 1)) begin
          pos_r <= '0;
        end
      end
      if (cmd.draw_out) begin
        pos_r <= pos_r + 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.draw_out) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_out) begin
      o_col_r <= cur_col_r;
      o_p1_r  <= spcfa_pkg::row_pos(row1_r);
      o_p2_r  <= spcfa_pkg::row_pos(row2_r);
      o_t_r   <= word[63];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.column_out      = o_col_r;
  assign out_ch.first_position  = o_p1_r;
  assign out_ch.second_position = o_p2_r;
  assign out_ch.first_treated   = o_t_r;

  assign sts.kind      = kind_r;
  assign sts.seeded    = seeded_r;
  assign sts.seed_last = (k_r == IW'(spcfa_pkg::TwN - 1));
  assign sts.rf_last   = (k_r == IW'(spcfa_pkg::TwN - 1));
  assign sts.pos_end   = (pos_r >= IW'(spcfa_pkg::TwN));
  assign sts.out_busy  = out_valid_r && !out_ch.ready;
  assign sts.mul_last  = mul_last;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= IW'(spcfa_pkg::TwN)) else $error("position beyond state size");
  a_draw_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_out |-> seeded_r) else $error("draw before seeding");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result dropped");
  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ph_r <= 2'd2) else $error("multiply phase out of range");
endmodule

/* rtl/spcfa_ctrl.sv */
// Controller state machine sequencing seeding, refill and draws.
module spcfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spcfa_pkg::dp_sts_t sts,
  output spcfa_pkg::dp_cmd_t cmd
);
  spcfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      spcfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = spcfa_pkg::ST_MIX0;
        end
      end
      spcfa_pkg::ST_MIX0: begin
        if (sts.kind == spcfa_pkg::KindColumn) begin
          cmd.mix_start = 1'b1;
          state_nxt = spcfa_pkg::ST_MIX1;
        end else if (!sts.seeded) begin
          state_nxt = spcfa_pkg::ST_IDLE;
        end else if (sts.pos_end) begin
          state_nxt = spcfa_pkg::ST_RF_RD0;
        end else begin
          state_nxt = spcfa_pkg::ST_DRAW_RD;
        end
      end
      spcfa_pkg::ST_MIX1: begin
        cmd.mix_step1 = 1'b1;
        if (sts.mul_last) begin
          state_nxt = spcfa_pkg::ST_MIX2;
        end
      end
      spcfa_pkg::ST_MIX2: begin
        cmd.mix_step2 = 1'b1;
        if (sts.mul_last) begin
          state_nxt = spcfa_pkg::ST_SEED;
        end
      end
      spcfa_pkg::ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (sts.mul_last && sts.seed_last) begin
          state_nxt = spcfa_pkg::ST_IDLE;
        end
      end
      spcfa_pkg::ST_RF_RD0: begin
        cmd.rf_rd0 = 1'b1;
        state_nxt = spcfa_pkg::ST_RF_RD1;
      end
      spcfa_pkg::ST_RF_RD1: begin
        cmd.rf_rd1 = 1'b1;
        state_nxt = spcfa_pkg::ST_RF_RD2;
      end
      spcfa_pkg::ST_RF_RD2: begin
        cmd.rf_rd2 = 1'b1;
        state_nxt = spcfa_pkg::ST_RF_WR;
      end
      spcfa_pkg::ST_RF_WR: begin
        cmd.rf_wr = 1'b1;
        state_nxt = sts.rf_last ? spcfa_pkg::ST_DRAW_RD : spcfa_pkg::ST_RF_RD0;
      end
      spcfa_pkg::ST_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_nxt = spcfa_pkg::ST_DRAW_OUT;
      end
      spcfa_pkg::ST_DRAW_OUT: begin
        if (!sts.out_busy) begin
          cmd.draw_out = 1'b1;
          state_nxt = spcfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spcfa_pkg::ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == spcfa_pkg::ST_IDLE) else $error("ready outside idle");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.mix_step2, cmd.seed_step, cmd.rf_wr}) <= 1) else $error("write clash");
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == spcfa_pkg::ST_MIX0) else $error("accept lost");
endmodule

/* rtl/seeded_pair_coin_flip_assigner_top.sv */
// Top level of the seeded matched-pair coin-flip assigner.
// A pair word passes decision, read and output states before its result is registered; the next
// word waits for idle. A draw that finds the state used up first refills it word by word (read k,
// k+1, k+M, write). A column word holds the input while it mixes the seed and writes 311 words.
// Synchronous active-low reset: unseeded, position 312, base seed 0, output empty.
// The state memory is not cleared; seeding writes it fully before any draw.
module seeded_pair_coin_flip_assigner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_column_number,
  input  logic [16:0] in_first_row,
  input  logic [16:0] in_second_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_column_out,
  output logic [15:0] out_first_position,
  output logic [15:0] out_second_position,
  output logic        out_first_treated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  spcfa_in_if  in_ch ();
  spcfa_out_if out_ch ();
  spcfa_cfg_if cfg_ch ();
  spcfa_pkg::dp_cmd_t cmd;
  spcfa_pkg::dp_sts_t sts;

  assign in_ch.valid         = in_valid;
  assign in_ch.kind          = in_kind;
  assign in_ch.column_number = in_column_number;
  assign in_ch.first_row     = in_first_row;
  assign in_ch.second_row    = in_second_row;
  assign in_ready            = in_ch.ready;

  assign out_valid           = out_ch.valid;
  assign out_ch.ready        = out_ready;
  assign out_column_out      = out_ch.column_out;
  assign out_first_position  = out_ch.first_position;
  assign out_second_position = out_ch.second_position;
  assign out_first_treated   = out_ch.first_treated;

  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data  = cfg_data;
  assign cfg_ready    = cfg_ch.ready;

  spcfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  spcfa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );
endmodule
